>>> rtl/dnp_pkg.sv
// shared types and constants for the dns name and record parser
package dnp_pkg;

  localparam int PKT_DEPTH_DEF = 4096;
  localparam int MAX_STEPS_DEF = 63;
  localparam int PW = 18;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_NAME     = 2'd1;
  localparam logic [1:0] MODE_QUESTION = 2'd2;
  localparam logic [1:0] MODE_RECORD   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BEYOND   = 3'd1;
  localparam logic [2:0] ST_RESERVED = 3'd2;
  localparam logic [2:0] ST_STEPS    = 3'd3;
  localparam logic [2:0] ST_SRV      = 3'd4;

  localparam logic [15:0] TYPE_SRV = 16'd33;

  typedef struct packed {
    logic        is_load;
    logic [1:0]  mode;
    logic [11:0] offset;
    logic [7:0]  data_byte;
    logic [12:0] packet_length;
  } item_t;

  typedef struct packed {
    logic [11:0] label_offset;
    logic [5:0]  label_length;
    logic        last;
    logic [2:0]  status;
    logic [12:0] name_length;
    logic [15:0] rec_type;
    logic        class_top_bit;
    logic [31:0] ttl;
    logic [12:0] rdata_offset;
    logic [15:0] rdata_length;
    logic [15:0] srv_port;
    logic [12:0] next_offset;
  } result_t;

endpackage

>>> rtl/dnp_front.sv
// input queue: accepts items, classifies load versus parse
module dnp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic [11:0]       offset,
  input  logic [7:0]        data_byte,
  input  logic [12:0]       packet_length,
  input  logic              pop,
  output logic              empty,
  output dnp_pkg::item_t    item
);
  import dnp_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      in_item;
  logic       do_push, do_pop;

  always_comb begin
    in_item.is_load       = (mode == MODE_LOAD);
    in_item.mode          = mode;
    in_item.offset        = offset;
    in_item.data_byte     = data_byte;
    in_item.packet_length = packet_length;
  end

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign item    = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/dnp_outq.sv
// result queue in front of the result ports
module dnp_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dnp_pkg::result_t  wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output dnp_pkg::result_t  rdata
);
  import dnp_pkg::*;

  result_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/dnp_engine.sv
// packet store and name walker: labels, pointers, fixed fields
module dnp_engine #(
  parameter int PKT_DEPTH = dnp_pkg::PKT_DEPTH_DEF,
  parameter int MAX_STEPS = dnp_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  dnp_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              o_push,
  output dnp_pkg::result_t  o_data,
  input  logic              o_full
);
  import dnp_pkg::*;

  localparam int AW = $clog2(PKT_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_STEP  = 9'b000000010,
    S_BYTE  = 9'b000000100,
    S_PTR   = 9'b000001000,
    S_FIX   = 9'b000010000,
    S_FXRD  = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_SRV   = 9'b010000000,
    S_FINAL = 9'b100000000
  } state_t;

  state_t          state_r;
  logic [7:0]      mem [PKT_DEPTH];
  logic [7:0]      rd_r;
  logic            re;
  logic [PW-1:0]   ra;
  logic            we;
  logic [PW-1:0]   wa;
  logic [PW-1:0]   cur_r, pos_r, len_r;
  logic [1:0]      mode_r;
  logic [5:0]      steps_r;
  logic [7:0]      b_r;
  logic            outer_r, name_ok_r;
  logic [12:0]     name_len_r;
  logic [3:0]      k_r;
  logic [79:0]     fx_r;
  logic [7:0]      port_r;
  result_t         fin_r;

  logic [7:0]      b;
  logic [PW-1:0]   len_in, p, start, nfix, target, lab_end, cur1;
  logic [12:0]     nl_zero;
  logic [15:0]     rdlen, rtype;
  logic            label_ok, label_push;
  result_t         lab;

  function automatic result_t fin_init(input logic [2:0] st);
    result_t f;
    f        = '0;
    f.last   = 1'b1;
    f.status = st;
    return f;
  endfunction

  always_comb begin
    b       = rd_r;
    len_in  = (PW'(q_item.packet_length) > PW'(PKT_DEPTH)) ? PW'(PKT_DEPTH)
                                                           : PW'(q_item.packet_length);
    p       = pos_r + PW'(name_len_r);
    start   = p + PW'(10);
    nfix    = (mode_r == MODE_QUESTION) ? PW'(4) : PW'(10);
    target  = PW'({b_r[5:0], rd_r});
    cur1    = cur_r + PW'(1);
    lab_end = cur1 + PW'(b);
    nl_zero = 13'(cur1 - pos_r);
    rdlen   = fx_r[15:0];
    rtype   = fx_r[79:64];
    label_ok = (b[7:6] == 2'b00) && (b != 8'd0) && !(lab_end > len_r);
    label_push = (state_r == S_BYTE) && label_ok && !o_full;
    lab = '0;
    lab.label_offset = cur1[11:0];
    lab.label_length = b[5:0];
  end

  always_comb begin
    q_pop = (state_r == S_IDLE) && !q_empty;
    we    = q_pop && q_item.is_load && (PW'(q_item.offset) < PW'(PKT_DEPTH));
    wa    = PW'(q_item.offset);
    re    = 1'b0;
    ra    = cur_r;
    unique case (state_r)
      S_STEP: begin
        re = (steps_r != 6'(MAX_STEPS)) && (cur_r < len_r);
      end
      S_BYTE: begin
        re = (b[7:6] == 2'b11) && (cur1 < len_r);
        ra = cur1;
      end
      S_FXRD: begin
        re = (PW'(k_r) < nfix);
        ra = p + PW'(k_r);
      end
      S_SRV: begin
        re = (k_r < 4'd2);
        ra = start + PW'(rdlen - rdlen) + PW'(4) + PW'(k_r);
      end
      default: ;
    endcase
    o_push = label_push || ((state_r == S_FINAL) && !o_full);
    o_data = (state_r == S_FINAL) ? fin_r : lab;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= q_item.data_byte;
    end
    if (re) begin
      rd_r <= mem[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && !q_item.is_load) begin
            pos_r      <= PW'(q_item.offset);
            cur_r      <= PW'(q_item.offset);
            len_r      <= len_in;
            mode_r     <= q_item.mode;
            steps_r    <= '0;
            outer_r    <= 1'b0;
            name_ok_r  <= 1'b0;
            name_len_r <= '0;
            state_r    <= S_STEP;
          end
        end
        S_STEP: begin
          if (steps_r == 6'(MAX_STEPS)) begin
            fin_r   <= fin_init(ST_STEPS);
            state_r <= S_FINAL;
          end else if (cur_r >= len_r) begin
            fin_r   <= fin_init(ST_BEYOND);
            state_r <= S_FINAL;
          end else begin
            fin_r   <= fin_init(ST_OK);
            state_r <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (b[7:6] == 2'b11) begin
            if (cur1 >= len_r) begin
              fin_r.status <= ST_BEYOND;
              state_r      <= S_FINAL;
            end else begin
              if (!outer_r) begin
                name_len_r <= 13'(cur_r + PW'(2) - pos_r);
                outer_r    <= 1'b1;
              end
              b_r     <= b;
              state_r <= S_PTR;
            end
          end else if (b[7:6] != 2'b00) begin
            fin_r.status <= ST_RESERVED;
            state_r      <= S_FINAL;
          end else if (b == 8'd0) begin
            name_ok_r <= 1'b1;
            if (!outer_r) begin
              name_len_r <= nl_zero;
            end
            if (mode_r == MODE_NAME) begin
              fin_r.name_length <= outer_r ? name_len_r : nl_zero;
              fin_r.next_offset <= 13'(pos_r + PW'(outer_r ? name_len_r : nl_zero));
              state_r           <= S_FINAL;
            end else begin
              state_r <= S_FIX;
            end
          end else if (lab_end > len_r) begin
            fin_r.status <= ST_BEYOND;
            state_r      <= S_FINAL;
          end else if (!o_full) begin
            cur_r   <= lab_end;
            steps_r <= steps_r + 6'd1;
            state_r <= S_STEP;
          end
        end
        S_PTR: begin
          if (target >= len_r) begin
            fin_r.status <= ST_BEYOND;
            state_r      <= S_FINAL;
          end else begin
            cur_r   <= target;
            steps_r <= steps_r + 6'd1;
            state_r <= S_STEP;
          end
        end
        S_FIX: begin
          fin_r.name_length <= name_len_r;
          k_r               <= '0;
          if (p + nfix > len_r) begin
            fin_r.status <= ST_BEYOND;
            state_r      <= S_FINAL;
          end else begin
            state_r <= S_FXRD;
          end
        end
        S_FXRD: begin
          if (k_r != 4'd0) begin
            fx_r <= {fx_r[71:0], rd_r};
          end
          if (PW'(k_r) == nfix) begin
            state_r <= S_EVAL;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_EVAL: begin
          k_r <= '0;
          if (mode_r == MODE_QUESTION) begin
            fin_r.rec_type      <= fx_r[31:16];
            fin_r.class_top_bit <= fx_r[15];
            fin_r.next_offset   <= 13'(p + PW'(4));
            state_r             <= S_FINAL;
          end else if (start + PW'(rdlen) > len_r) begin
            fin_r.status <= ST_BEYOND;
            state_r      <= S_FINAL;
          end else if ((rtype == TYPE_SRV) && (rdlen < 16'd6)) begin
            fin_r.status <= ST_SRV;
            state_r      <= S_FINAL;
          end else begin
            fin_r.rec_type      <= rtype;
            fin_r.class_top_bit <= fx_r[63];
            fin_r.ttl           <= fx_r[47:16];
            fin_r.rdata_offset  <= 13'(start);
            fin_r.rdata_length  <= rdlen;
            fin_r.next_offset   <= 13'(start + PW'(rdlen));
            state_r             <= (rtype == TYPE_SRV) ? S_SRV : S_FINAL;
          end
        end
        S_SRV: begin
          port_r <= rd_r;
          if (k_r == 4'd2) begin
            fin_r.srv_port <= {port_r, rd_r};
            state_r        <= S_FINAL;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_FINAL: begin
          if (!o_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full) else $error("result pushed into a full queue");
  a_ptr_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PTR) |-> $past(state_r == S_BYTE)) else $error("pointer state out of order");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (steps_r <= 6'(MAX_STEPS))) else $error("step count overran");

endmodule

>>> rtl/dns_name_record_parser.sv
// top level: dns name, question and record parser over a loaded packet
//
//  channel   direction  handshake            fields
//  in_       input      in_push / in_full    mode, offset, data_byte, packet_length
//  out_      output     out_pop / out_empty  label and final result fields
//
//  a load item only writes the packet store; a parse takes the item, walks each label,
//  pointer and the closing zero byte, then reads the fixed fields of a question or record
//  and the port of an srv record before it pushes the final item, all through the single
//  read port of the packet store
//  items queue two deep on each side, so either side may stall on its own
//  rst_n clears the queues and the walker; the packet store keeps its contents
module dns_name_record_parser #(
  parameter int PKT_DEPTH = dnp_pkg::PKT_DEPTH_DEF,
  parameter int MAX_STEPS = dnp_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_offset,
  input  logic [7:0]  in_data_byte,
  input  logic [12:0] in_packet_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_label_offset,
  output logic [5:0]  out_label_length,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [12:0] out_name_length,
  output logic [15:0] out_rec_type,
  output logic        out_class_top_bit,
  output logic [31:0] out_ttl,
  output logic [12:0] out_rdata_offset,
  output logic [15:0] out_rdata_length,
  output logic [15:0] out_srv_port,
  output logic [12:0] out_next_offset
);
  import dnp_pkg::*;

  item_t   q_item;
  logic    q_empty, q_pop;
  logic    o_push, o_full;
  result_t o_data, r;

  dnp_front u_front (
    .clk, .rst_n,
    .push(in_push), .full(in_full),
    .mode(in_mode), .offset(in_offset), .data_byte(in_data_byte),
    .packet_length(in_packet_length),
    .pop(q_pop), .empty(q_empty), .item(q_item)
  );

  dnp_engine #(.PKT_DEPTH(PKT_DEPTH), .MAX_STEPS(MAX_STEPS)) u_engine (
    .clk, .rst_n,
    .q_empty, .q_item, .q_pop,
    .o_push, .o_data, .o_full
  );

  dnp_outq u_outq (
    .clk, .rst_n,
    .push(o_push), .wdata(o_data), .full(o_full),
    .pop(out_pop), .empty(out_empty), .rdata(r)
  );

  assign out_label_offset  = r.label_offset;
  assign out_label_length  = r.label_length;
  assign out_last          = r.last;
  assign out_status        = r.status;
  assign out_name_length   = r.name_length;
  assign out_rec_type      = r.rec_type;
  assign out_class_top_bit = r.class_top_bit;
  assign out_ttl           = r.ttl;
  assign out_rdata_offset  = r.rdata_offset;
  assign out_rdata_length  = r.rdata_length;
  assign out_srv_port      = r.srv_port;
  assign out_next_offset   = r.next_offset;

endmodule

>>> bench/dnp_checker.sv
// checker for the dns name parser: predicts results of accepted items and compares
`timescale 1ns / 1ps
module dnp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_offset,
  input  logic [7:0]  in_data_byte,
  input  logic [12:0] in_packet_length,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [11:0] out_label_offset,
  input  logic [5:0]  out_label_length,
  input  logic        out_last,
  input  logic [2:0]  out_status,
  input  logic [12:0] out_name_length,
  input  logic [15:0] out_rec_type,
  input  logic        out_class_top_bit,
  input  logic [31:0] out_ttl,
  input  logic [12:0] out_rdata_offset,
  input  logic [15:0] out_rdata_length,
  input  logic [15:0] out_srv_port,
  input  logic [12:0] out_next_offset,
  output int          fails,
  output int          pending
);
  import dnp_pkg::*;

  logic [7:0] pkt_mirror [4096];
  result_t    expected_q [$];

  initial fails = 0;
  assign pending = expected_q.size();

  function automatic int unsigned byte_at(int unsigned a);
    return (a < 4096) ? int'(pkt_mirror[a]) : 0;
  endfunction

  function automatic int unsigned word_at(int unsigned a);
    return (byte_at(a) << 8) | byte_at(a + 1);
  endfunction

  task automatic walk_name(input logic [1:0] mode, input int unsigned pos,
                           input int unsigned plen);
    int unsigned cur, b, target, nlen, p, rtype, rdlen, start, len;
    logic [2:0] st;
    bit name_ok, outer_set;
    result_t r;
    int steps;
    len = (plen > 4096) ? 4096 : plen;
    cur = pos;
    st = ST_STEPS;
    nlen = 0;
    name_ok = 0;
    outer_set = 0;
    for (steps = 0; steps < MAX_STEPS_DEF; steps++) begin
      if (cur >= len) begin
        st = ST_BEYOND;
        break;
      end
      b = byte_at(cur);
      if ((b & 'hc0) == 'hc0) begin
        if (cur + 1 >= len) begin
          st = ST_BEYOND;
          break;
        end
        if (!outer_set) begin
          nlen = cur + 2 - pos;
          outer_set = 1;
        end
        target = ((b & 'h3f) << 8) | byte_at(cur + 1);
        if (target >= len) begin
          st = ST_BEYOND;
          break;
        end
        cur = target;
        continue;
      end
      if ((b & 'hc0) != 0) begin
        st = ST_RESERVED;
        break;
      end
      if (b == 0) begin
        if (!outer_set) nlen = cur + 1 - pos;
        name_ok = 1;
        st = ST_OK;
        break;
      end
      if (cur + 1 + b > len) begin
        st = ST_BEYOND;
        break;
      end
      r = '0;
      r.label_offset = 12'(cur + 1);
      r.label_length = 6'(b);
      expected_q.insert(expected_q.size(), r);
      cur += 1 + b;
    end
    r = '0;
    r.last = 1'b1;
    if (name_ok) begin
      p = pos + nlen;
      r.name_length = 13'(nlen);
      if (mode == MODE_NAME) begin
        r.next_offset = 13'(p);
      end else if (mode == MODE_QUESTION) begin
        if (p + 4 > len) st = ST_BEYOND;
        else begin
          r.rec_type = 16'(word_at(p));
          r.class_top_bit = 1'(word_at(p + 2) >> 15);
          r.next_offset = 13'(p + 4);
        end
      end else begin
        if (p + 10 > len) st = ST_BEYOND;
        else begin
          rtype = word_at(p);
          rdlen = word_at(p + 8);
          start = p + 10;
          if (start + rdlen > len) st = ST_BEYOND;
          else if (rtype == TYPE_SRV && rdlen < 6) st = ST_SRV;
          else begin
            r.rec_type = 16'(rtype);
            r.class_top_bit = 1'(word_at(p + 2) >> 15);
            r.ttl = (word_at(p + 4) << 16) | word_at(p + 6);
            r.rdata_offset = 13'(start);
            r.rdata_length = 16'(rdlen);
            if (rtype == TYPE_SRV) r.srv_port = 16'(word_at(start + 4));
            r.next_offset = 13'(start + rdlen);
          end
        end
      end
      if (st != ST_OK) begin
        r = '0;
        r.last = 1'b1;
        r.name_length = 13'(nlen);
      end
    end
    r.status = st;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    fails++;
  endtask

  task automatic compare_result();
    result_t e;
    if (expected_q.size() == 0) begin
      report("unexpected item", 32'd0, 32'd1);
      return;
    end
    e = expected_q.pop_front();
    if (out_label_offset !== e.label_offset)
      report("label_offset", 32'(e.label_offset), 32'(out_label_offset));
    if (out_label_length !== e.label_length)
      report("label_length", 32'(e.label_length), 32'(out_label_length));
    if (out_last !== e.last)
      report("last", 32'(e.last), 32'(out_last));
    if (out_status !== e.status)
      report("status", 32'(e.status), 32'(out_status));
    if (out_name_length !== e.name_length)
      report("name_length", 32'(e.name_length), 32'(out_name_length));
    if (out_rec_type !== e.rec_type)
      report("rec_type", 32'(e.rec_type), 32'(out_rec_type));
    if (out_class_top_bit !== e.class_top_bit)
      report("class_top_bit", 32'(e.class_top_bit), 32'(out_class_top_bit));
    if (out_ttl !== e.ttl)
      report("ttl", e.ttl, out_ttl);
    if (out_rdata_offset !== e.rdata_offset)
      report("rdata_offset", 32'(e.rdata_offset), 32'(out_rdata_offset));
    if (out_rdata_length !== e.rdata_length)
      report("rdata_length", 32'(e.rdata_length), 32'(out_rdata_length));
    if (out_srv_port !== e.srv_port)
      report("srv_port", 32'(e.srv_port), 32'(out_srv_port));
    if (out_next_offset !== e.next_offset)
      report("next_offset", 32'(e.next_offset), 32'(out_next_offset));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (in_mode == MODE_LOAD) pkt_mirror[in_offset] <= in_data_byte;
        else walk_name(in_mode, in_offset, in_packet_length);
      end
      if (out_pop && !out_empty) compare_result();
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench top for the dns name parser: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
  import dnp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_mode;
  logic [11:0] in_offset;
  logic [7:0]  in_data_byte;
  logic [12:0] in_packet_length;
  logic        out_empty;
  logic        out_pop;
  logic [11:0] out_label_offset;
  logic [5:0]  out_label_length;
  logic        out_last;
  logic [2:0]  out_status;
  logic [12:0] out_name_length;
  logic [15:0] out_rec_type;
  logic        out_class_top_bit;
  logic [31:0] out_ttl;
  logic [12:0] out_rdata_offset;
  logic [15:0] out_rdata_length;
  logic [15:0] out_srv_port;
  logic [12:0] out_next_offset;
  int          fails;
  int          pending;
  int          quiet_cycles;
  bit          no_gaps;
  logic [7:0]  pkt_buf [512];
  int          pkt_len;
  int          name_starts [$];

  dns_name_record_parser dut (.*);
  dnp_checker chk (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [1:0] mode, int off, int db, int plen);
    bit taken;
    int g;
    in_push <= 1'b1;
    in_mode <= mode;
    in_offset <= 12'(off);
    in_data_byte <= 8'(db);
    in_packet_length <= 13'(plen);
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
    g = gap_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_buf();
    for (int i = 0; i < pkt_len; i++) send(MODE_LOAD, i, pkt_buf[i], $urandom);
  endtask

  task automatic put(int b);
    pkt_buf[pkt_len] = 8'(b);
    pkt_len++;
  endtask

  // name, then the fixed record fields and rdata; names may point back to earlier ones
  task automatic build_packet();
    int s, nl, ln, rtype, rdlen, tgt;
    pkt_len = 0;
    name_starts.delete();
    while (pkt_len < 64) begin
      s = pkt_len;
      nl = $urandom_range(0, 4);
      for (int i = 0; i < nl; i++) begin
        ln = $urandom_range(1, 12);
        put(ln);
        for (int j = 0; j < ln; j++) put($urandom_range(0, 255));
      end
      if (name_starts.size() > 0 && $urandom_range(0, 1)) begin
        tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
        put('hc0 | (tgt >> 8));
        put(tgt & 'hff);
      end else if ($urandom_range(0, 9) == 0) begin
        put($urandom_range(0, 255));
      end else begin
        put(0);
      end
      name_starts.insert(name_starts.size(), s);
      case ($urandom_range(0, 5))
        0: rtype = 1;
        1: rtype = 12;
        2: rtype = 16;
        3: rtype = 28;
        4: rtype = 33;
        default: rtype = $urandom_range(0, 65535);
      endcase
      rdlen = (rtype == 33) ? $urandom_range(0, 10) : $urandom_range(0, 8);
      put(rtype >> 8);
      put(rtype);
      put($urandom_range(0, 255));
      put($urandom_range(0, 255));
      for (int i = 0; i < 4; i++) put($urandom_range(0, 255));
      put(rdlen >> 8);
      put(rdlen);
      for (int i = 0; i < rdlen; i++) put($urandom_range(0, 255));
    end
  endtask

  // a start at or past the bound reads nothing, so any length is safe; a length of 4096 or more starts at byte 4095
  task automatic send_noise();
    int plen, lo;
    plen = $urandom_range(0, 8191);
    if (plen >= 4096) send($urandom_range(1, 3), 4095, $urandom, plen);
    else begin
      lo = plen;
      send($urandom_range(1, 3), $urandom_range(lo, 4095), $urandom, plen);
    end
  endtask

  initial begin
    int r, plen;
    byte unsigned directed [] = '{
      3, "a", "b", "c", 0, 8'h00, 8'h21, 8'h80, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78,
      8'h00, 8'h08, 0, 1, 0, 2, 8'h1f, 8'h90, 8'hee, 8'hff,
      8'hc0, 8'h00, 8'h00, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h78,
      8'h00, 8'h02, 8'hab, 8'hcd,
      8'hc0, 8'h25, 8'h40, 8'h80};
    rst_n = 1'b0;
    in_push = 1'b0;
    in_mode = MODE_LOAD;
    in_offset = '0;
    in_data_byte = '0;
    in_packet_length = '0;
    out_pop = 1'b0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pkt_len = 0;
    foreach (directed[i]) put(directed[i]);
    put(63);
    for (int i = 0; i < 63; i++) put("x");
    put(0);
    foreach (directed[i]) if (i >= 5 && i < 15) put(directed[i]);
    pkt_buf[pkt_len - 2] = 8'h00;
    pkt_buf[pkt_len - 1] = 8'h02;
    put(8'hab);
    put(8'hcd);
    load_buf();
    send(MODE_LOAD, 4095, 0, 0);
    send(MODE_NAME, 0, 0, pkt_len);
    send(MODE_QUESTION, 0, 0, pkt_len);
    send(MODE_RECORD, 0, 0, pkt_len);
    send(MODE_RECORD, 23, 0, pkt_len);
    send(MODE_NAME, 37, 0, pkt_len);
    send(MODE_NAME, 39, 0, pkt_len);
    send(MODE_NAME, 40, 0, pkt_len);
    send(MODE_NAME, 41, 0, pkt_len);
    send(MODE_RECORD, 41, 0, pkt_len);
    send(MODE_NAME, 0, 0, 3);
    send(MODE_QUESTION, 0, 0, 7);
    send(MODE_RECORD, 23, 0, 24);
    send(MODE_RECORD, 0, 0, 20);
    send(MODE_NAME, 4095, 0, 4096);
    send(MODE_RECORD, 4095, 0, 8191);
    send(MODE_QUESTION, 4000, 0, 100);
    send(MODE_NAME, 0, 0, 0);

    for (int ph = 0; ph < 2; ph++) begin
      no_gaps = (ph % 3 == 1);
      build_packet();
      load_buf();
      for (int k = 0; k < 42; k++) begin
        r = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, pkt_len) : pkt_len;
        if (r < 70)
          send($urandom_range(1, 3), name_starts[$urandom_range(0, name_starts.size() - 1)],
               $urandom, plen);
        else if (r < 90) send($urandom_range(1, 3), $urandom_range(0, pkt_len - 1), $urandom, plen);
        else send_noise();
      end
    end
    in_push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // result side: bursts of pops with random stalls
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

endmodule
